FILE: rtl/core/rss_pkg.sv
// ----------------------------------------------------------------------------
// rss_pkg
// Shared types and codes for the record stack with key search.
// ----------------------------------------------------------------------------
package rss_pkg;

    localparam int ID_W  = 32;
    localparam int AVG_W = 10;
    localparam int CNT_W = 7;

    localparam logic [AVG_W-1:0] AVG_MAX = 10'd1000;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [AVG_W-1:0] avg;
    } rec_t;

    typedef logic [1:0] op_t;

    localparam op_t OP_HOLD = 2'd0;
    localparam op_t OP_PUSH = 2'd1;
    localparam op_t OP_POP  = 2'd2;
    localparam op_t OP_ROT  = 2'd3;

    localparam logic [1:0] FN_PUSH   = 2'd0;
    localparam logic [1:0] FN_POP    = 2'd1;
    localparam logic [1:0] FN_SEARCH = 2'd2;
    localparam logic [1:0] FN_SIZE   = 2'd3;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_EMPTY    = 2'd1;
    localparam logic [1:0] STAT_FULL     = 2'd2;
    localparam logic [1:0] STAT_NOTFOUND = 2'd3;

endpackage

FILE: rtl/core/rss_cell.sv
// ----------------------------------------------------------------------------
// rss_cell
// One stack slot: holds a record and takes its neighbor's record on a shift.
// ----------------------------------------------------------------------------
module rss_cell
(
    input  logic          clk,
    input  rss_pkg::op_t  op,
    input  rss_pkg::rec_t above_rec,
    input  rss_pkg::rec_t below_rec,
    output rss_pkg::rec_t rec
);

    rss_pkg::rec_t rec_reg;
    rss_pkg::rec_t rec_next;

    always_comb
    begin
        unique case (op)
            rss_pkg::OP_PUSH: rec_next = above_rec;
            rss_pkg::OP_POP:  rec_next = below_rec;
            rss_pkg::OP_ROT:  rec_next = below_rec;
            default:          rec_next = rec_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

    assign rec = rec_reg;

endmodule

FILE: rtl/core/rss_chain.sv
// ----------------------------------------------------------------------------
// rss_chain
// Row of stack cells, top of stack in cell zero; rotates as a ring for search.
// ----------------------------------------------------------------------------
module rss_chain
#(
    parameter int DEPTH = 64
)
(
    input  logic          clk,
    input  rss_pkg::op_t  op,
    input  rss_pkg::rec_t push_rec,
    output rss_pkg::rec_t top_rec
);

    rss_pkg::rec_t cell_rec [DEPTH];

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            rss_pkg::rec_t above;
            rss_pkg::rec_t below;

            if (i == 0)
            begin : g_first
                assign above = push_rec;
            end
            else
            begin : g_mid_a
                assign above = cell_rec[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_last
                assign below = cell_rec[0];
            end
            else
            begin : g_mid_b
                assign below = cell_rec[i+1];
            end

            rss_cell u_cell
            (
                .clk       (clk),
                .op        (op),
                .above_rec (above),
                .below_rec (below),
                .rec       (cell_rec[i])
            );
        end
    endgenerate

    assign top_rec = cell_rec[0];

endmodule

FILE: rtl/core/record_stack_with_key_search_core.sv
// ----------------------------------------------------------------------------
// record_stack_with_key_search_core
// LIFO stack of id/average records with search by identifier.
// ----------------------------------------------------------------------------
// usage:
//   an operation beat is taken when start is high and busy is low (func,
//   key_id, average_in). results appear on status, record_id,
//   record_average, entry_count and last, marked by result_strobe;
//   the receiver cannot stall, so every result is taken in its cycle.
//   push, pop and size: one result in the cycle after the beat, and a new beat
//   may follow in the very next cycle (one item per cycle).
//   search: the cell ring rotates through all STACK_DEPTH cells, one cell a
//   cycle, comparing the top cell; busy stays high through the scan and the
//   flush. each match is shown the cycle after the next match is found,
//   the final result (last set, or a single not-found) in the cycle in which
//   busy falls, when a new beat may already be taken.
//   cfg_we/cfg_wdata write the capacity limit; writing only while idle is up to the user, unenforced by the block.
//   reset empties the stack and sets the capacity limit to 64.
// ----------------------------------------------------------------------------
module record_stack_with_key_search_core
#(
    parameter int STACK_DEPTH = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  func,
    input  logic [31:0] key_id,
    input  logic [9:0]  average_in,
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata,
    output logic        result_strobe,
    output logic [1:0]  status,
    output logic [31:0] record_id,
    output logic [9:0]  record_average,
    output logic [6:0]  entry_count,
    output logic        last
);

    localparam int SCAN_W = $clog2(STACK_DEPTH + 1);
    localparam logic [SCAN_W-1:0] SCAN_END = SCAN_W'(STACK_DEPTH - 1);
    localparam logic [rss_pkg::CNT_W-1:0] DEPTH_CNT = rss_pkg::CNT_W'(STACK_DEPTH);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_FLUSH = 2'd2;

    logic [1:0]                state_reg, state_next;
    logic [rss_pkg::CNT_W-1:0] count_reg, count_next;
    logic [rss_pkg::CNT_W-1:0] cap_reg;
    logic [SCAN_W-1:0]         scan_reg, scan_next;
    logic [31:0]               key_reg, key_next;
    rss_pkg::rec_t             pend_reg, pend_next;
    logic                      pend_vld_reg, pend_vld_next;

    logic                      strobe_reg, strobe_next;
    logic [1:0]                status_reg, status_next;
    rss_pkg::rec_t             res_reg, res_next;
    logic                      last_reg, last_next;

    rss_pkg::op_t              op;
    rss_pkg::rec_t             push_rec;
    rss_pkg::rec_t             top_rec;
    logic [rss_pkg::CNT_W-1:0] limit;
    logic                      hit;

    rss_chain #(.DEPTH(STACK_DEPTH)) u_chain
    (
        .clk      (clk),
        .op       (op),
        .push_rec (push_rec),
        .top_rec  (top_rec)
    );

    assign limit = (cap_reg > DEPTH_CNT) ? DEPTH_CNT : cap_reg;
    assign hit   = (rss_pkg::CNT_W'(scan_reg) < count_reg) && (top_rec.id == key_reg);

    always_comb
    begin
        push_rec.id  = key_id;
        push_rec.avg = (average_in > rss_pkg::AVG_MAX) ? rss_pkg::AVG_MAX : average_in;
    end

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        scan_next     = scan_reg;
        key_next      = key_reg;
        pend_next     = pend_reg;
        pend_vld_next = pend_vld_reg;
        strobe_next   = 1'b0;
        status_next   = rss_pkg::STAT_OK;
        res_next      = '0;
        last_next     = 1'b1;
        op            = rss_pkg::OP_HOLD;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    strobe_next = 1'b1;
                    unique case (func)
                        rss_pkg::FN_PUSH:
                        begin
                            if (count_reg >= limit)
                            begin
                                status_next = rss_pkg::STAT_FULL;
                            end
                            else
                            begin
                                op         = rss_pkg::OP_PUSH;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        rss_pkg::FN_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = rss_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                op         = rss_pkg::OP_POP;
                                count_next = count_reg - 1'b1;
                                res_next   = top_rec;
                            end
                        end
                        rss_pkg::FN_SEARCH:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = rss_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                strobe_next   = 1'b0;
                                state_next    = S_SCAN;
                                scan_next     = '0;
                                key_next      = key_id;
                                pend_vld_next = 1'b0;
                            end
                        end
                        default:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = rss_pkg::STAT_EMPTY;
                            end
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                op = rss_pkg::OP_ROT;
                if (hit)
                begin
                    strobe_next   = pend_vld_reg;
                    res_next      = pend_reg;
                    last_next     = 1'b0;
                    pend_next     = top_rec;
                    pend_vld_next = 1'b1;
                end
                scan_next = scan_reg + 1'b1;
                if (scan_reg == SCAN_END)
                begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                strobe_next = 1'b1;
                if (pend_vld_reg)
                begin
                    res_next = pend_reg;
                end
                else
                begin
                    status_next = rss_pkg::STAT_NOTFOUND;
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            cap_reg      <= 7'd64;
            pend_vld_reg <= 1'b0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            pend_vld_reg <= pend_vld_next;
            strobe_reg   <= strobe_next;
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg   <= scan_next;
        key_reg    <= key_next;
        pend_reg   <= pend_next;
        status_reg <= status_next;
        res_reg    <= res_next;
        last_reg   <= last_next;
    end

    assign busy           = (state_reg != S_IDLE);
    assign result_strobe  = strobe_reg;
    assign status         = status_reg;
    assign record_id      = res_reg.id;
    assign record_average = res_reg.avg;
    assign entry_count    = count_reg;
    assign last           = last_reg;

endmodule

FILE: sim/record_stack_with_key_search_core_test.sv
// ----------------------------------------------------------------------------
// record_stack_with_key_search_core_test
// Self-checking bench for the record stack: a queue-fed driver issues push,
// pop, search and size beats with random gaps, and a shadow stack predicts
// every result beat, which the monitor checks field by field.
// ----------------------------------------------------------------------------
module record_stack_with_key_search_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STACK_DEPTH = 64;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE      = 3;

    typedef enum logic [1:0] {KIND_OP, KIND_CFG, KIND_DRAIN} stim_kind_t;

    typedef struct {
        stim_kind_t  kind;
        logic [1:0]  fn;
        logic [31:0] key;
        logic [9:0]  avg;
        logic [6:0]  cap;
        int          gap;
    } stim_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] id;
        logic [9:0]  avg;
        logic [6:0]  count;
        logic        last;
    } reply_t;

    logic        clk;
    logic        rst_n          = 1'b0;
    logic        start          = 1'b0;
    logic        busy;
    logic [1:0]  func           = rss_pkg::FN_PUSH;
    logic [31:0] key_id         = '0;
    logic [9:0]  average_in     = '0;
    logic        cfg_we         = 1'b0;
    logic [6:0]  cfg_wdata      = '0;
    logic        result_strobe;
    logic [1:0]  status;
    logic [31:0] record_id;
    logic [9:0]  record_average;
    logic [6:0]  entry_count;
    logic        last;

    stim_t  op_queue[$];
    reply_t due_replies[$];

    logic [31:0] shadow_id[STACK_DEPTH];
    logic [9:0]  shadow_avg[STACK_DEPTH];
    int          shadow_depth = 0;
    logic [6:0]  shadow_cap   = 7'd64;

    int   mismatches   = 0;
    int   cycle_count  = 0;
    int   gap_left     = 0;
    int   quiet_cycles = 0;
    int   run_left     = 0;
    bit   no_gaps      = 1'b0;
    bit   beat_taken   = 1'b0;
    logic drive_start;
    logic drive_we;

    logic [31:0] key_pool[4] = '{32'h0000_0001, 32'hA5A5_5A5A, 32'h8000_0000, 32'h7FFF_FFFE};

    record_stack_with_key_search_core #(
        .STACK_DEPTH(STACK_DEPTH)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .func(func),
        .key_id(key_id),
        .average_in(average_in),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .result_strobe(result_strobe),
        .status(status),
        .record_id(record_id),
        .record_average(record_average),
        .entry_count(entry_count),
        .last(last)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic apply_to_shadow_stack(input logic [1:0] fn, input logic [31:0] key,
                                         input logic [9:0] avg_in);
        int     limit;
        int     hits;
        reply_t r;
        limit = (shadow_cap > STACK_DEPTH) ? STACK_DEPTH : int'(shadow_cap);
        hits  = 0;
        r     = '0;
        r.last = 1'b1;
        case (fn)
            rss_pkg::FN_PUSH:
            begin
                if (shadow_depth >= limit)
                    r.status = rss_pkg::STAT_FULL;
                else
                begin
                    shadow_id[shadow_depth]  = key;
                    shadow_avg[shadow_depth] = (avg_in > rss_pkg::AVG_MAX) ?
                                               rss_pkg::AVG_MAX : avg_in;
                    shadow_depth++;
                    r.status = rss_pkg::STAT_OK;
                end
            end
            rss_pkg::FN_POP:
            begin
                if (shadow_depth == 0)
                    r.status = rss_pkg::STAT_EMPTY;
                else
                begin
                    shadow_depth--;
                    r.status = rss_pkg::STAT_OK;
                    r.id     = shadow_id[shadow_depth];
                    r.avg    = shadow_avg[shadow_depth];
                end
            end
            rss_pkg::FN_SEARCH:
            begin
                if (shadow_depth == 0)
                    r.status = rss_pkg::STAT_EMPTY;
                else
                begin
                    for (int i = shadow_depth - 1; i >= 0; i--)
                    begin
                        if (shadow_id[i] == key)
                        begin
                            due_replies.push_back('{rss_pkg::STAT_OK, shadow_id[i],
                                                    shadow_avg[i],
                                                    7'(shadow_depth), 1'b0});
                            hits++;
                        end
                    end
                    if (hits == 0)
                        r.status = rss_pkg::STAT_NOTFOUND;
                    else
                        due_replies[$].last = 1'b1;
                end
            end
            default:
            begin
                r.status = (shadow_depth == 0) ? rss_pkg::STAT_EMPTY : rss_pkg::STAT_OK;
            end
        endcase
        r.count = 7'(shadow_depth);
        if (hits == 0)
            due_replies.push_back(r);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("[record_stack_with_key_search_core] ERROR");
                $finish;
            end
            else
            begin
                if (result_strobe)
                begin
                    if (due_replies.size() == 0)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"unexpected result beat: ",
                                      "status %0d id %h avg %0d cnt %0d last %b"},
                                     status, record_id, record_average, entry_count,
                                     last);
                    end
                    else
                    begin
                        reply_t want;
                        want = due_replies.pop_front();
                        if (status !== want.status || record_id !== want.id ||
                            record_average !== want.avg || entry_count !== want.count ||
                            last !== want.last)
                        begin
                            mismatches++;
                            if (mismatches <= 10)
                                $display({"result mismatch: ",
                                          "want st %0d id %h avg %0d cnt %0d last %b, ",
                                          "got st %0d id %h avg %0d cnt %0d last %b"},
                                         want.status, want.id, want.avg, want.count,
                                         want.last, status, record_id, record_average,
                                         entry_count, last);
                        end
                    end
                end
                if (cfg_we)
                    shadow_cap = cfg_wdata;
                if (start && !busy)
                begin
                    beat_taken = 1'b1;
                    apply_to_shadow_stack(func, key_id, average_in);
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            drive_start = start;
            drive_we    = 1'b0;
            if (start && beat_taken)
                drive_start = 1'b0;
            beat_taken = 1'b0;
            if (due_replies.size() == 0 && !busy && !start && !cfg_we)
                quiet_cycles++;
            else
                quiet_cycles = 0;
            if (!drive_start)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (op_queue.size() > 0)
                begin
                    case (op_queue[0].kind)
                        KIND_OP:
                        begin
                            func        <= op_queue[0].fn;
                            key_id      <= op_queue[0].key;
                            average_in  <= op_queue[0].avg;
                            gap_left    = op_queue[0].gap;
                            drive_start = 1'b1;
                            void'(op_queue.pop_front());
                        end
                        KIND_CFG:
                        begin
                            if (quiet_cycles >= SETTLE)
                            begin
                                cfg_wdata <= op_queue[0].cap;
                                drive_we  = 1'b1;
                                void'(op_queue.pop_front());
                            end
                        end
                        default:
                        begin
                            if (quiet_cycles >= SETTLE)
                                void'(op_queue.pop_front());
                        end
                    endcase
                end
            end
            start  <= drive_start;
            cfg_we <= drive_we;
        end
    end

    task automatic queue_op(input logic [1:0] fn, input logic [31:0] key,
                            input logic [9:0] avg);
        stim_t s;
        if (run_left == 0)
        begin
            run_left = $urandom_range(4, 16);
            no_gaps  = ($urandom_range(0, 2) == 0);
        end
        run_left--;
        s.kind = KIND_OP;
        s.fn   = fn;
        s.key  = key;
        s.avg  = avg;
        s.cap  = '0;
        s.gap  = no_gaps ? 0 : $urandom_range(0, 14);
        op_queue.push_back(s);
    endtask

    task automatic queue_cfg(input logic [6:0] cap);
        stim_t s;
        s.kind = KIND_CFG;
        s.fn   = rss_pkg::FN_PUSH;
        s.key  = '0;
        s.avg  = '0;
        s.cap  = cap;
        s.gap  = 0;
        op_queue.push_back(s);
    endtask

    task automatic queue_drain();
        stim_t s;
        s.kind = KIND_DRAIN;
        s.fn   = rss_pkg::FN_PUSH;
        s.key  = '0;
        s.avg  = '0;
        s.cap  = '0;
        s.gap  = 0;
        op_queue.push_back(s);
    endtask

    function automatic logic [31:0] pick_key();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return 32'h0000_0000;
        else if (r == 1)
            return 32'hFFFF_FFFF;
        else if (r <= 3)
            return $urandom;
        return key_pool[r % 4];
    endfunction

    function automatic logic [9:0] pick_avg();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 10'($urandom_range(1001, 1023));
        else if (r == 1)
            return $urandom_range(0, 1) ? rss_pkg::AVG_MAX : 10'd0;
        return 10'($urandom_range(0, 1000));
    endfunction

    task automatic queue_random_ops(input int n, input int push_w, input int pop_w,
                                    input int search_w);
        int r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < push_w)
                queue_op(rss_pkg::FN_PUSH, pick_key(), pick_avg());
            else if (r < push_w + pop_w)
                queue_op(rss_pkg::FN_POP, $urandom, 10'($urandom));
            else if (r < push_w + pop_w + search_w)
                queue_op(rss_pkg::FN_SEARCH, pick_key(), 10'($urandom));
            else
                queue_op(rss_pkg::FN_SIZE, $urandom, 10'($urandom));
        end
    endtask

    initial
    begin
        // directed: empty stack, extremes, saturation, multi-match and not-found search
        queue_op(rss_pkg::FN_SIZE,   32'h0, 10'd0);
        queue_op(rss_pkg::FN_POP,    32'h0, 10'd0);
        queue_op(rss_pkg::FN_SEARCH, 32'h0, 10'd0);
        queue_op(rss_pkg::FN_PUSH,   32'h0000_0000, 10'd0);
        queue_op(rss_pkg::FN_PUSH,   32'hFFFF_FFFF, 10'd1000);
        queue_op(rss_pkg::FN_PUSH,   32'h0000_0000, 10'd1023);
        queue_op(rss_pkg::FN_PUSH,   32'h0000_0005, 10'd500);
        queue_op(rss_pkg::FN_SEARCH, 32'h0000_0000, 10'd0);
        queue_op(rss_pkg::FN_SEARCH, 32'h0001_2345, 10'd0);
        queue_op(rss_pkg::FN_SEARCH, 32'hFFFF_FFFF, 10'h3FF);
        queue_op(rss_pkg::FN_SIZE,   32'hFFFF_FFFF, 10'h3FF);
        repeat (5) queue_op(rss_pkg::FN_POP, 32'h0, 10'd0);
        // capacity of one
        queue_cfg(7'd1);
        queue_op(rss_pkg::FN_PUSH,   32'h0000_0007, 10'd7);
        queue_op(rss_pkg::FN_PUSH,   32'h0000_0008, 10'd8);
        queue_op(rss_pkg::FN_SEARCH, 32'h0000_0007, 10'd0);
        // capacity zero refuses every push
        queue_cfg(7'd0);
        queue_op(rss_pkg::FN_PUSH,   32'h0000_0009, 10'd9);
        queue_op(rss_pkg::FN_POP,    32'h0, 10'd0);
        // capacity lowered below the count
        queue_cfg(7'd64);
        repeat (3) queue_op(rss_pkg::FN_PUSH, pick_key(), pick_avg());
        queue_cfg(7'd2);
        queue_op(rss_pkg::FN_PUSH,   32'h0000_000A, 10'd10);
        queue_op(rss_pkg::FN_POP,    32'h0, 10'd0);
        queue_op(rss_pkg::FN_PUSH,   32'h0000_000B, 10'd11);
        queue_op(rss_pkg::FN_POP,    32'h0, 10'd0);
        queue_op(rss_pkg::FN_PUSH,   32'h0000_000C, 10'd12);

        // random: capacity above the depth, push heavy so the stack grows
        queue_cfg(7'd127);
        queue_random_ops(30, 80, 5, 10);
        queue_drain();
        queue_random_ops(30, 75, 5, 15);
        queue_cfg(7'($urandom_range(1, 63)));
        queue_random_ops(30, 30, 35, 20);
        queue_cfg(7'd64);
        queue_random_ops(35, 40, 30, 20);

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (op_queue.size() != 0 || start || cfg_we)
            @(posedge clk);
        while (due_replies.size() != 0)
            @(posedge clk);
        repeat (2 * STACK_DEPTH + 8) @(posedge clk);
        if (due_replies.size() != 0)
            mismatches++;

        if (mismatches == 0)
            $display("[record_stack_with_key_search_core] OK");
        else
            $display("[record_stack_with_key_search_core] ERROR");
        $finish;
    end

endmodule
